/* design/icmp_probe_reply_matcher_defines.svh */
// assertion macros for the icmp probe reply matcher
// used by modules that check their own control logic; needs clk and rst_n in scope
`ifndef ICMP_PROBE_REPLY_MATCHER_DEFINES_SVH
`define ICMP_PROBE_REPLY_MATCHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRM_ASSERT_NOW(lbl, ante, cons)
`define PRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/icmp_prm_pkg.sv */
// shared types, codes and helpers for the icmp probe reply matcher
// no dependencies
`timescale 1ns / 1ps
package icmp_prm_pkg;

  localparam logic [3:0] V_ECHO     = 4'd0;
  localparam logic [3:0] V_TTL      = 4'd1;
  localparam logic [3:0] V_UNREACH  = 4'd2;
  localparam logic [3:0] V_NOT_V4   = 4'd3;
  localparam logic [3:0] V_SHORT    = 4'd4;
  localparam logic [3:0] V_TRUNC    = 4'd5;
  localparam logic [3:0] V_IP_SUM   = 4'd6;
  localparam logic [3:0] V_NOT_ICMP = 4'd7;
  localparam logic [3:0] V_ICMP_SUM = 4'd8;
  localparam logic [3:0] V_FOREIGN  = 4'd9;
  localparam logic [3:0] V_OTHER    = 4'd10;

  localparam logic [7:0] T_ECHO_REPLY = 8'd0;
  localparam logic [7:0] T_UNREACH    = 8'd3;
  localparam logic [7:0] T_ECHO_REQ   = 8'd8;
  localparam logic [7:0] T_TIME_EXC   = 8'd11;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] OPT_RR       = 8'd7;

  localparam logic [1:0] CFG_IP_ID    = 2'd0;
  localparam logic [1:0] CFG_ICMP_ID  = 2'd1;
  localparam logic [1:0] CFG_ICMP_SEQ = 2'd2;
  localparam logic [1:0] CFG_RR_ON    = 2'd3;

  typedef struct packed {
    logic [7:0]  vihl;
    logic [15:0] tl;
    logic [15:0] ipid;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [7:0]  rr_ptr;
    logic [31:0] src;
    logic [7:0]  typ;
    logic [7:0]  code;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [15:0] hcks;
    logic [15:0] icks;
    logic [7:0]  q_vihl;
    logic [7:0]  q_ttl;
    logic [15:0] q_ipid;
    logic [7:0]  q_type;
    logic [15:0] q_id;
    logic [15:0] q_seq;
    logic [7:0]  opt_type;
  } fld_t;

  typedef struct packed {
    logic [15:0] n;
    logic [15:0] hsum;
    logic [15:0] isum;
    logic [3:0]  rp;
    fld_t        f;
  } snap_t;

  typedef struct packed {
    logic [15:0] ip_id;
    logic [15:0] icmp_id;
    logic [15:0] icmp_seq;
    logic        rr_on;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] src;
    logic [7:0]  ttl;
    logic [7:0]  typ;
    logic [7:0]  code;
    logic [15:0] ipid;
    logic [7:0]  qttl;
    logic [3:0]  count;
  } res_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  verdict;
    logic [31:0] src;
    logic [7:0]  ttl;
    logic [7:0]  typ;
    logic [7:0]  code;
    logic [15:0] ipid;
    logic [7:0]  qttl;
    logic [31:0] addr;
    logic        fin;
  } item_t;

  function automatic logic [15:0] sum_add(input logic [15:0] sum, input logic odd,
                                          input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, sum} + (odd ? {9'd0, b} : {1'b0, b, 8'd0});
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

/* design/icmp_prm_parse.sv */
// byte parser: running checksums, captured header fields, route store, packet snapshot
// depends on icmp_prm_pkg and icmp_probe_reply_matcher_defines.svh
`timescale 1ns / 1ps
`include "icmp_probe_reply_matcher_defines.svh"
module icmp_prm_parse import icmp_prm_pkg::*; #(
  parameter int MAX_PACKET_BYTES  = 2048,
  parameter int MAX_ROUTE_ENTRIES = 9,
  parameter int RIW = (MAX_ROUTE_ENTRIES > 1) ? $clog2(MAX_ROUTE_ENTRIES) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_byte,
  input  logic           in_end,
  input  logic           route_busy,
  input  logic           b_take,
  output logic           b_valid,
  output snap_t          snap,
  input  logic [RIW-1:0] rd_idx,
  output logic [31:0]    rd_data
);
  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   hsum_r, hsum_nxt, isum_r, isum_nxt;
  logic [3:0]    rp_r, rp_nxt;
  fld_t          f_r, f_nxt;
  logic          b_valid_r;
  snap_t         snap_r;
  logic [31:0]   route_mem [MAX_ROUTE_ENTRIES];

  logic          active, fire, route_wr;
  logic [16:0]   p17, hl4, rel1, q, rel2, ih4, r, hl4r, rbase, a;
  logic [RIW-1:0] e;

  assign active = pos_r < PW'(MAX_PACKET_BYTES);
  assign p17    = 17'(pos_r);
  assign hl4r   = {11'd0, f_r.vihl[3:0], 2'b00};
  assign rbase  = hl4r + 17'd31;
  assign a      = p17 - rbase;
  assign e      = a[RIW+1:2];
  assign route_wr = active && (pos_r != '0) && (p17 >= rbase) &&
                    (p17 < rbase + 17'(4 * MAX_ROUTE_ENTRIES));

  assign in_tready = (!b_valid_r || b_take) && !(route_wr && (b_valid_r || route_busy));
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    f_nxt    = f_r;
    hsum_nxt = hsum_r;
    isum_nxt = isum_r;
    rp_nxt   = rp_r;
    pos_nxt  = pos_r;
    hl4  = '0;
    rel1 = '0;
    q    = '0;
    rel2 = '0;
    ih4  = '0;
    r    = '0;
    if (active) begin
      if (pos_r == '0) f_nxt.vihl = in_byte;
      hl4 = {11'd0, f_nxt.vihl[3:0], 2'b00};
      if (p17 == 17'd2 || p17 == 17'd3) f_nxt.tl = {f_r.tl[7:0], in_byte};
      else if (p17 == 17'd4 || p17 == 17'd5) f_nxt.ipid = {f_r.ipid[7:0], in_byte};
      else if (p17 == 17'd8) f_nxt.ttl = in_byte;
      else if (p17 == 17'd9) f_nxt.proto = in_byte;
      else if (p17 == 17'd10 || p17 == 17'd11) f_nxt.hcks = {f_r.hcks[7:0], in_byte};
      else if (p17 >= 17'd12 && p17 <= 17'd15) f_nxt.src = {f_r.src[23:0], in_byte};
      if (p17 < hl4 && p17 != 17'd10 && p17 != 17'd11)
        hsum_nxt = sum_add(hsum_r, pos_r[0], in_byte);
      if (p17 >= hl4) begin
        rel1 = p17 - hl4;
        if (p17 >= 17'd4 && p17 < {1'b0, f_nxt.tl} && rel1 != 17'd2 && rel1 != 17'd3)
          isum_nxt = sum_add(isum_r, pos_r[0], in_byte);
        if (rel1 == 17'd0) f_nxt.typ = in_byte;
        else if (rel1 == 17'd1) f_nxt.code = in_byte;
        else if (rel1 == 17'd2 || rel1 == 17'd3) f_nxt.icks = {f_r.icks[7:0], in_byte};
        else if (rel1 == 17'd4 || rel1 == 17'd5)
          f_nxt.echo_id = {f_r.echo_id[7:0], in_byte};
        else if (rel1 == 17'd6 || rel1 == 17'd7)
          f_nxt.echo_seq = {f_r.echo_seq[7:0], in_byte};
      end
      q = hl4 + 17'd8;
      if (p17 >= q) begin
        rel2 = p17 - q;
        if (rel2 == 17'd0) f_nxt.q_vihl = in_byte;
        ih4 = {11'd0, f_nxt.q_vihl[3:0], 2'b00};
        if (rel2 == 17'd4 || rel2 == 17'd5) f_nxt.q_ipid = {f_r.q_ipid[7:0], in_byte};
        else if (rel2 == 17'd8) f_nxt.q_ttl = in_byte;
        else if (rel2 == 17'd20) f_nxt.opt_type = in_byte;
        else if (rel2 == 17'd22) f_nxt.rr_ptr = in_byte;
        if (rel2 >= ih4) begin
          r = rel2 - ih4;
          if (r == 17'd0) f_nxt.q_type = in_byte;
          else if (r == 17'd4 || r == 17'd5) f_nxt.q_id = {f_r.q_id[7:0], in_byte};
          else if (r == 17'd6 || r == 17'd7) f_nxt.q_seq = {f_r.q_seq[7:0], in_byte};
        end
      end
      if (route_wr && a[1:0] == 2'd3) rp_nxt = 4'(e) + 4'd1;
      pos_nxt = pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hsum_r    <= '0;
      isum_r    <= '0;
      rp_r      <= '0;
      f_r       <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (in_end) begin
          pos_r  <= '0;
          hsum_r <= '0;
          isum_r <= '0;
          rp_r   <= '0;
          f_r    <= '0;
        end else begin
          pos_r  <= pos_nxt;
          hsum_r <= hsum_nxt;
          isum_r <= isum_nxt;
          rp_r   <= rp_nxt;
          f_r    <= f_nxt;
        end
      end
      if (fire && in_end) b_valid_r <= 1'b1;
      else if (b_take) b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_end) begin
      snap_r.n    <= 16'(pos_nxt);
      snap_r.hsum <= hsum_nxt;
      snap_r.isum <= isum_nxt;
      snap_r.rp   <= rp_nxt;
      snap_r.f    <= f_nxt;
    end
    if (fire && route_wr) begin
      if (a[1:0] == 2'd0) route_mem[e] <= {24'd0, in_byte};
      else route_mem[e] <= {route_mem[e][23:0], in_byte};
    end
  end

  assign rd_data = route_mem[rd_idx];
  assign b_valid = b_valid_r;
  assign snap    = snap_r;

  `PRM_ASSERT_NEXT(a_snap_hold, b_valid_r && !b_take, b_valid_r && $stable(snap_r.n))
  `PRM_ASSERT_NOW(a_no_route_overwrite, fire && route_wr, !b_valid_r && !route_busy)
  `PRM_ASSERT_NEXT(a_end_clears, fire && in_end, pos_r == '0 && rp_r == 4'd0)
endmodule

/* design/icmp_prm_class.sv */
// verdict logic: classifies a finished packet snapshot against the configured probe
// depends on icmp_prm_pkg
`timescale 1ns / 1ps
module icmp_prm_class import icmp_prm_pkg::*; #(
  parameter int MAX_ROUTE_ENTRIES = 9
) (
  input  snap_t snap,
  input  cfg_t  cfg,
  output res_t  res
);
  logic [5:0] hl4, ih4, c6;
  logic [7:0] p;
  logic       qmatch;

  assign hl4 = {snap.f.vihl[3:0], 2'b00};
  assign ih4 = {snap.f.q_vihl[3:0], 2'b00};
  assign p   = snap.f.rr_ptr;
  assign qmatch = snap.f.q_type == T_ECHO_REQ && snap.f.q_ipid == cfg.ip_id &&
                  snap.f.q_id == cfg.icmp_id && snap.f.q_seq == cfg.icmp_seq;

  always_comb begin
    res.verdict = V_OTHER;
    res.src   = snap.f.src;
    res.ttl   = snap.f.ttl;
    res.typ   = snap.f.typ;
    res.code  = snap.f.code;
    res.ipid  = snap.f.ipid;
    res.qttl  = 8'd0;
    res.count = 4'd0;
    c6 = (p >= 8'd4) ? 6'((p - 8'd4) >> 2) : 6'd0;
    if (snap.f.vihl[7:4] != 4'd4) res.verdict = V_NOT_V4;
    else if (snap.n < 16'd20) res.verdict = V_SHORT;
    else if (snap.n < snap.f.tl) res.verdict = V_TRUNC;
    else if (hl4 < 6'd20 || {10'd0, hl4} + 16'd8 > snap.f.tl) res.verdict = V_SHORT;
    else if (~snap.hsum != snap.f.hcks) res.verdict = V_IP_SUM;
    else if (snap.f.proto != PROTO_ICMP) res.verdict = V_NOT_ICMP;
    else if (~snap.isum != snap.f.icks) res.verdict = V_ICMP_SUM;
    else if (snap.f.typ == T_ECHO_REPLY) begin
      res.verdict = (snap.f.echo_id == cfg.icmp_id && snap.f.echo_seq == cfg.icmp_seq) ?
                    V_ECHO : V_FOREIGN;
    end else if (snap.f.typ == T_TIME_EXC || snap.f.typ == T_UNREACH) begin
      if (qmatch) begin
        res.verdict = (snap.f.typ == T_TIME_EXC) ? V_TTL : V_UNREACH;
        res.qttl = snap.f.q_ttl;
        if (cfg.rr_on && ih4 > 6'd20 && snap.f.opt_type == OPT_RR) begin
          if (c6 > 6'(MAX_ROUTE_ENTRIES)) c6 = 6'(MAX_ROUTE_ENTRIES);
          if (c6 > {2'd0, snap.rp}) c6 = {2'd0, snap.rp};
          res.count = c6[3:0];
        end
      end else begin
        res.verdict = V_FOREIGN;
      end
    end
    if (res.verdict == V_NOT_V4 || res.verdict == V_SHORT || res.verdict == V_TRUNC) begin
      res.src  = '0;
      res.ttl  = '0;
      res.typ  = '0;
      res.code = '0;
      res.ipid = '0;
      res.qttl = '0;
    end
  end
endmodule

/* design/icmp_prm_emit.sv */
// result register and route address sequencer
// depends on icmp_prm_pkg and icmp_probe_reply_matcher_defines.svh
`timescale 1ns / 1ps
`include "icmp_probe_reply_matcher_defines.svh"
module icmp_prm_emit import icmp_prm_pkg::*; #(
  parameter int MAX_ROUTE_ENTRIES = 9,
  parameter int RIW = (MAX_ROUTE_ENTRIES > 1) ? $clog2(MAX_ROUTE_ENTRIES) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           b_valid,
  input  res_t           res,
  output logic           b_take,
  output logic           route_busy,
  output logic [RIW-1:0] rd_idx,
  input  logic [31:0]    rd_data,
  output logic           out_valid,
  input  logic           out_tready,
  output item_t          item
);
  logic           out_valid_r;
  item_t          item_r;
  logic [3:0]     left_r;
  logic [RIW-1:0] idx_r;
  logic           can_load, adv;

  assign can_load = !out_valid_r || out_tready;
  assign b_take   = b_valid && can_load && left_r == 4'd0;
  assign adv      = out_valid_r && out_tready && left_r != 4'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
      idx_r       <= '0;
    end else begin
      if (b_take) begin
        out_valid_r <= 1'b1;
        left_r      <= res.count;
        idx_r       <= '0;
      end else if (adv) begin
        out_valid_r <= 1'b1;
        left_r      <= left_r - 4'd1;
        idx_r       <= idx_r + RIW'(1);
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      item_r.kind    <= 1'b0;
      item_r.verdict <= res.verdict;
      item_r.src     <= res.src;
      item_r.ttl     <= res.ttl;
      item_r.typ     <= res.typ;
      item_r.code    <= res.code;
      item_r.ipid    <= res.ipid;
      item_r.qttl    <= res.qttl;
      item_r.addr    <= '0;
      item_r.fin     <= res.count == 4'd0;
    end else if (adv) begin
      item_r <= {1'b1, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, rd_data,
                 left_r == 4'd1};
    end
  end

  assign route_busy = left_r != 4'd0;
  assign rd_idx     = idx_r;
  assign out_valid  = out_valid_r;
  assign item       = item_r;

  `PRM_ASSERT_NOW(a_left_shows, left_r != 4'd0, out_valid_r)
  `PRM_ASSERT_NOW(a_fin_verdict, out_valid_r && !item_r.kind, item_r.fin == (left_r == 4'd0))
  `PRM_ASSERT_NOW(a_left_max, 1'b1, left_r <= 4'(MAX_ROUTE_ENTRIES))
endmodule

/* design/icmp_probe_reply_matcher.sv */
// top level of the icmp probe reply matcher: config registers, parser, classifier, emitter
// depends on icmp_prm_pkg, icmp_prm_parse, icmp_prm_class, icmp_prm_emit
//
// channel   direction  transfer
// in_*      slave      one packet byte, tlast on the last byte
// out_*     master     verdict item, then 0..9 route address items, tlast on the last
// cfg_*     slave      register write, index and 16 bit data
//
// one byte per cycle while the parser runs; a packet's snapshot is registered at its last
// byte and its verdict passes through the classifier into the result register.
// route items follow one per cycle while out_tready is high; a byte stalls when it would
// write the route store before the previous packet's verdict and addresses are out, and
// any byte stalls while the previous verdict cannot yet load into the result register.
// reset clears all control state; out_tready low holds the result register.
`timescale 1ns / 1ps
module icmp_probe_reply_matcher import icmp_prm_pkg::*; #(
  parameter int MAX_PACKET_BYTES  = 2048,
  parameter int MAX_ROUTE_ENTRIES = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // packet_byte
  input  logic         in_tlast,   // packet_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // verdict, reply_source, reply_ttl, reply_type,
                                   // reply_code, reply_ip_id, quoted_ttl, route_address
  output logic         out_tuser,  // item_kind
  output logic         out_tlast,  // final_item
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam int RIW = (MAX_ROUTE_ENTRIES > 1) ? $clog2(MAX_ROUTE_ENTRIES) : 1;

  cfg_t           cfg_r;
  logic           b_valid, b_take, route_busy;
  snap_t          snap;
  res_t           res;
  item_t          item;
  logic [RIW-1:0] rd_idx;
  logic [31:0]    rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IP_ID:    cfg_r.ip_id    <= cfg_data;
        CFG_ICMP_ID:  cfg_r.icmp_id  <= cfg_data;
        CFG_ICMP_SEQ: cfg_r.icmp_seq <= cfg_data;
        CFG_RR_ON:    cfg_r.rr_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  icmp_prm_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .MAX_ROUTE_ENTRIES(MAX_ROUTE_ENTRIES),
    .RIW(RIW)
  ) u_parse (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_byte(in_tdata), .in_end(in_tlast),
    .route_busy(route_busy), .b_take(b_take), .b_valid(b_valid), .snap(snap),
    .rd_idx(rd_idx), .rd_data(rd_data)
  );

  icmp_prm_class #(.MAX_ROUTE_ENTRIES(MAX_ROUTE_ENTRIES)) u_class (
    .snap(snap), .cfg(cfg_r), .res(res)
  );

  icmp_prm_emit #(.MAX_ROUTE_ENTRIES(MAX_ROUTE_ENTRIES), .RIW(RIW)) u_emit (
    .clk(clk), .rst_n(rst_n),
    .b_valid(b_valid), .res(res), .b_take(b_take), .route_busy(route_busy),
    .rd_idx(rd_idx), .rd_data(rd_data),
    .out_valid(out_tvalid), .out_tready(out_tready), .item(item)
  );

  assign out_tdata = {4'd0, item.addr, item.qttl, item.ipid, item.code, item.typ,
                      item.ttl, item.src, item.verdict};
  assign out_tuser = item.kind;
  assign out_tlast = item.fin;
endmodule
